### rtl/ftidx_pkg.sv
package ftidx_pkg;

    // Fixed field widths
    localparam int TIME_W = 64;
    localparam int IDX_W  = 11;
    localparam int QI_W   = 10;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    // Default table depth
    localparam int MAX_ENTRIES_DEF = 1024;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND_TIME = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND_DEPS = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOKEY = 2'd3;

    // Index value for "none"
    localparam logic [IDX_W-1:0] NONE_IDX = '1;

endpackage

### rtl/ftidx_mem.sv
module ftidx_mem
    import ftidx_pkg::*;
#(
    parameter int DEPTH = MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(MAX_ENTRIES_DEF)
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic signed [TIME_W-1:0] wtime,
    input  logic                     wkey,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output logic signed [TIME_W-1:0] rtime,
    output logic                     rkey
);

    // Entry word: key flag over start time
    logic [TIME_W:0] ram_reg [DEPTH];
    logic [TIME_W:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= {wkey, wtime};
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_reg <= ram_reg[raddr];
        end
    end

    assign rtime = rd_reg[TIME_W-1:0];
    assign rkey  = rd_reg[TIME_W];

endmodule

### rtl/ftidx_cmp.sv
module ftidx_cmp
    import ftidx_pkg::*;
(
    input  logic signed [TIME_W-1:0] lhs,
    input  logic signed [TIME_W-1:0] rhs,
    output logic                     gt
);

    // Shared signed (two's complement) greater-than compare
    assign gt = (lhs > rhs);

endmodule

### rtl/frame_timestamp_index_top.sv
// Append and clear: the result word is registered in the cycle after the input word is taken.
// Timestamp query: reads the first and then the last entry, then a binary search over the rest,
// each search step a read through the single registered read port and a compare.
// Dependency query: walks back from the queried entry to the nearest keyframe, one entry read
// per cycle. One word at a time: appends and clears can go every cycle while m_ready is high.
// Reset (synchronous, active low) empties the table; entry storage is not cleared.
module frame_timestamp_index_top
    import ftidx_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_cmd,
    input  logic signed [TIME_W-1:0] s_time_value,
    input  logic                     s_key_flag,
    input  logic [QI_W-1:0]          s_query_index,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic signed [IDX_W-1:0]  m_found_frame,
    output logic signed [IDX_W-1:0]  m_base_keyframe,
    output logic signed [IDX_W-1:0]  m_predecessor
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_T_FIRST = 3'd1;
    localparam logic [2:0] S_T_LAST  = 3'd2;
    localparam logic [2:0] S_T_ISSUE = 3'd3;
    localparam logic [2:0] S_T_MID   = 3'd4;
    localparam logic [2:0] S_D_SCAN  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] lo_reg, lo_next;
    logic [IW-1:0] hi_reg, hi_next;
    logic [IW-1:0] mid_reg, mid_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic signed [TIME_W-1:0] t_reg, t_next;

    logic                    m_valid_reg;
    logic [STAT_W-1:0]       status_reg;
    logic [IDX_W-1:0]        found_reg, base_reg, pred_reg;

    logic                    mem_we, mem_re;
    logic [IW-1:0]           mem_raddr;
    logic signed [TIME_W-1:0] rd_time;
    logic                    rd_key;

    logic                    cmp_swap, cmp_gt;
    logic signed [TIME_W-1:0] cmp_lhs, cmp_rhs;

    logic                    fin;
    logic [STAT_W-1:0]       fin_status;
    logic [IDX_W-1:0]        fin_found, fin_base, fin_pred;

    logic                    accept;
    logic [IW:0]             mid_sum;

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + {{IW{1'b0}}, 1'b1};

    // Entry storage
    ftidx_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (count_reg[IW-1:0]),
        .wtime (s_time_value),
        .wkey  (s_key_flag),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rtime (rd_time),
        .rkey  (rd_key)
    );

    // Shared compare; swap tests query > entry instead of entry > query
    assign cmp_lhs = cmp_swap ? t_reg : rd_time;
    assign cmp_rhs = cmp_swap ? rd_time : t_reg;

    ftidx_cmp u_cmp (
        .lhs (cmp_lhs),
        .rhs (cmp_rhs),
        .gt  (cmp_gt)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        t_next     = t_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        cmp_swap   = 1'b0;
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_found  = NONE_IDX;
        fin_base   = NONE_IDX;
        fin_pred   = NONE_IDX;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    t_next = s_time_value;
                    case (s_cmd)
                        CMD_CLEAR: begin
                            count_next = '0;
                            fin        = 1'b1;
                        end
                        CMD_APPEND: begin
                            fin = 1'b1;
                            if (count_reg < CW'(MAX_ENTRIES)) begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end else begin
                                fin_status = ST_FULL;
                            end
                        end
                        CMD_FIND_TIME: begin
                            if (count_reg < CW'(2)) begin
                                fin        = 1'b1;
                                fin_status = ST_MISS;
                            end else begin
                                mem_re     = 1'b1;
                                state_next = S_T_FIRST;
                            end
                        end
                        default: begin
                            if (32'(s_query_index) >= 32'(count_reg)) begin
                                fin        = 1'b1;
                                fin_status = ST_MISS;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = IW'(s_query_index);
                                k_next     = IW'(s_query_index);
                                idx_next   = IW'(s_query_index);
                                state_next = S_D_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_T_FIRST: begin
                // first entry above the query: out of range
                if (cmp_gt) begin
                    fin        = 1'b1;
                    fin_status = ST_MISS;
                    state_next = S_IDLE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = IW'(count_reg - CW'(1));
                    state_next = S_T_LAST;
                end
            end
            S_T_LAST: begin
                // query beyond end marker: out of range
                cmp_swap = 1'b1;
                if (cmp_gt) begin
                    fin        = 1'b1;
                    fin_status = ST_MISS;
                    state_next = S_IDLE;
                end else begin
                    lo_next    = '0;
                    hi_next    = IW'(count_reg - CW'(2));
                    state_next = S_T_ISSUE;
                end
            end
            S_T_ISSUE: begin
                if (lo_reg < hi_reg) begin
                    mem_re     = 1'b1;
                    mem_raddr  = mid_sum[IW:1];
                    mid_next   = mid_sum[IW:1];
                    state_next = S_T_MID;
                end else begin
                    fin        = 1'b1;
                    fin_found  = IDX_W'(lo_reg);
                    state_next = S_IDLE;
                end
            end
            S_T_MID: begin
                if (cmp_gt) begin
                    hi_next = mid_reg - IW'(1);
                end else begin
                    lo_next = mid_reg;
                end
                state_next = S_T_ISSUE;
            end
            S_D_SCAN: begin
                // walk back one entry a cycle to the nearest keyframe
                if (rd_key) begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                    if (k_reg != idx_reg) begin
                        fin_base = IDX_W'(k_reg);
                        fin_pred = IDX_W'(idx_reg - IW'(1));
                    end
                end else if (k_reg == '0) begin
                    fin        = 1'b1;
                    fin_status = ST_NOKEY;
                    state_next = S_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = k_reg - IW'(1);
                    k_next    = k_reg - IW'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        k_reg   <= k_next;
        idx_reg <= idx_next;
        t_reg   <= t_next;
        if (fin) begin
            status_reg <= fin_status;
            found_reg  <= fin_found;
            base_reg   <= fin_base;
            pred_reg   <= fin_pred;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_found_frame   = found_reg;
    assign m_base_keyframe = base_reg;
    assign m_predecessor   = pred_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_busy_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !m_valid_reg)
        else $error("result word pending while a query is in progress");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_cmd == CMD_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the table");
`endif

endmodule
